// File: hw/rtl/mseu_pkg.sv
`timescale 1ns / 1ps
package mseu_pkg;

	typedef enum logic [2:0] {
		ST_OK             = 3'd0,
		ST_SYSCALL        = 3'd1,
		ST_EXIT           = 3'd2,
		ST_ILLEGAL_INSTR  = 3'd3,
		ST_ILLEGAL_SYSCALL = 3'd4,
		ST_MEM_FAULT      = 3'd5,
		ST_HALTED         = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		SZ_BYTE = 2'd0,
		SZ_HALF = 2'd1,
		SZ_WORD = 2'd2
	} size_t;

	localparam logic [31:0] RESET_PC  = 32'h0000_1000;
	localparam logic [31:0] PC_REGION = 32'hf000_0000;

	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_SLTI    = 6'h0a;
	localparam logic [5:0] OP_SLTIU   = 6'h0b;
	localparam logic [5:0] OP_ANDI    = 6'h0c;
	localparam logic [5:0] OP_ORI     = 6'h0d;
	localparam logic [5:0] OP_XORI    = 6'h0e;
	localparam logic [5:0] OP_LUI     = 6'h0f;
	localparam logic [5:0] OP_LB      = 6'h20;
	localparam logic [5:0] OP_LH      = 6'h21;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_LBU     = 6'h24;
	localparam logic [5:0] OP_LHU     = 6'h25;
	localparam logic [5:0] OP_SB      = 6'h28;
	localparam logic [5:0] OP_SH      = 6'h29;
	localparam logic [5:0] OP_SW      = 6'h2b;

	localparam logic [5:0] FN_SLL     = 6'h00;
	localparam logic [5:0] FN_SRL     = 6'h02;
	localparam logic [5:0] FN_SRA     = 6'h03;
	localparam logic [5:0] FN_JR      = 6'h08;
	localparam logic [5:0] FN_JALR    = 6'h09;
	localparam logic [5:0] FN_SYSCALL = 6'h0c;
	localparam logic [5:0] FN_ADDU    = 6'h21;
	localparam logic [5:0] FN_SUBU    = 6'h23;
	localparam logic [5:0] FN_AND     = 6'h24;
	localparam logic [5:0] FN_OR      = 6'h25;
	localparam logic [5:0] FN_XOR     = 6'h26;
	localparam logic [5:0] FN_NOR     = 6'h27;
	localparam logic [5:0] FN_SLT     = 6'h2a;
	localparam logic [5:0] FN_SLTU    = 6'h2b;

	localparam logic [31:0] SYS_PRINT_INT  = 32'd1;
	localparam logic [31:0] SYS_PRINT_STR  = 32'd4;
	localparam logic [31:0] SYS_EXIT       = 32'd10;
	localparam logic [31:0] SYS_PRINT_CHAR = 32'd11;

	localparam logic [4:0] REG_ZERO     = 5'd0;
	localparam logic [4:0] REG_SYS_CODE = 5'd2;
	localparam logic [4:0] REG_SYS_ARG  = 5'd4;
	localparam logic [4:0] REG_RA       = 5'd31;

	typedef struct packed {
		logic [31:0] npc;
		status_t     status;
		logic        wb_valid;
		logic [4:0]  wb_reg;
		logic [31:0] wb_value;
		logic        sys_out;
		logic        ld_issue;
		logic        st_en;
		logic        halt_set;
		logic [31:0] addr;
		logic [3:0]  byte_en;
		logic [31:0] st_data;
	} exec_t;

endpackage

// File: hw/rtl/mseu_regfile.sv
`timescale 1ns / 1ps
module mseu_regfile import mseu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rd_en,
	input  logic [4:0]  ra,
	input  logic [4:0]  rb,
	input  logic        we,
	input  logic [4:0]  wa,
	input  logic [31:0] wd,
	input  logic        clr_en,
	input  logic [4:0]  clr_idx,
	output logic [31:0] a_q,
	output logic [31:0] b_q,
	output logic [31:0] r2_q,
	output logic [31:0] r4_q
);

	logic [31:0] rf [32];

	always_ff @(posedge clk) begin
		if (clr_en) begin
			rf[clr_idx] <= '0;
		end else if (we) begin
			rf[wa] <= wd;
		end
	end

	// A write landing at the same edge as the read is forwarded.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			a_q <= (we && wa == ra) ? wd : rf[ra];
			b_q <= (we && wa == rb) ? wd : rf[rb];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r2_q <= '0;
			r4_q <= '0;
		end else if (we) begin
			if (wa == REG_SYS_CODE) r2_q <= wd;
			if (wa == REG_SYS_ARG) r4_q <= wd;
		end
	end

endmodule

// File: hw/rtl/mseu_exec.sv
`timescale 1ns / 1ps
module mseu_exec import mseu_pkg::*; #(
	parameter int MEM_WORDS = 4096
) (
	input  logic [31:0] ins,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] pc,
	input  logic [31:0] r2,
	input  logic        halted,
	input  logic [31:0] rdata,
	output exec_t       x
);

	localparam longint MEM_BYTES = longint'(MEM_WORDS) * 4;

	logic [5:0]  op, funct;
	logic [4:0]  rt, rd, shamt;
	logic [31:0] imm_z, imm_s, pc4, br_tgt, j_tgt, sh_data;
	logic        wr, is_load, is_store, ld_signed, addr_ok, fault;
	logic [4:0]  wreg;
	logic [31:0] wval, ld_val;
	status_t     st;
	size_t       size;

	assign op        = ins[31:26];
	assign rt        = ins[20:16];
	assign rd        = ins[15:11];
	assign shamt     = ins[10:6];
	assign funct     = ins[5:0];
	assign imm_z     = {16'h0000, ins[15:0]};
	assign imm_s     = {{16{ins[15]}}, ins[15:0]};
	assign pc4       = pc + 32'd4;
	assign br_tgt    = pc4 + {imm_s[29:0], 2'b00};
	assign j_tgt     = (pc4 & PC_REGION) | {4'h0, ins[25:0], 2'b00};
	assign sh_data   = rdata >> {x.addr[1:0], 3'b000};

	always_comb begin
		x         = '0;
		x.addr    = a + imm_s;
		x.npc     = pc4;
		st        = ST_OK;
		wr        = 1'b0;
		wreg      = '0;
		wval      = '0;
		is_load   = 1'b0;
		is_store  = 1'b0;
		ld_signed = 1'b0;
		size      = SZ_WORD;
		case (op)
			OP_SPECIAL: begin
				wr   = 1'b1;
				wreg = rd;
				case (funct)
					FN_SLL:  wval = b << shamt;
					FN_SRL:  wval = b >> shamt;
					FN_SRA:  wval = $unsigned($signed(b) >>> shamt);
					FN_JR: begin
						wr    = 1'b0;
						x.npc = a;
					end
					FN_JALR: begin
						wval  = pc4;
						x.npc = a;
					end
					FN_SYSCALL: begin
						wr = 1'b0;
						if (r2 == SYS_PRINT_INT || r2 == SYS_PRINT_STR ||
							r2 == SYS_PRINT_CHAR) begin
							st = ST_SYSCALL;
						end else if (r2 == SYS_EXIT) begin
							st = ST_EXIT;
						end else begin
							st = ST_ILLEGAL_SYSCALL;
						end
					end
					FN_ADDU: wval = a + b;
					FN_SUBU: wval = a - b;
					FN_AND:  wval = a & b;
					FN_OR:   wval = a | b;
					FN_XOR:  wval = a ^ b;
					FN_NOR:  wval = ~(a | b);
					FN_SLT:  wval = {31'd0, $signed(a) < $signed(b)};
					FN_SLTU: wval = {31'd0, a < b};
					default: begin
						wr = 1'b0;
						st = ST_ILLEGAL_INSTR;
					end
				endcase
			end
			OP_J:   x.npc = j_tgt;
			OP_JAL: begin
				wr    = 1'b1;
				wreg  = REG_RA;
				wval  = pc4;
				x.npc = j_tgt;
			end
			OP_BEQ: if (a == b) x.npc = br_tgt;
			OP_BNE: if (a != b) x.npc = br_tgt;
			OP_ADDIU: begin wr = 1'b1; wreg = rt; wval = a + imm_s; end
			OP_SLTI: begin
				wr = 1'b1; wreg = rt; wval = {31'd0, $signed(a) < $signed(imm_s)};
			end
			OP_SLTIU: begin wr = 1'b1; wreg = rt; wval = {31'd0, a < imm_s}; end
			OP_ANDI: begin wr = 1'b1; wreg = rt; wval = a & imm_z; end
			OP_ORI:  begin wr = 1'b1; wreg = rt; wval = a | imm_z; end
			OP_XORI: begin wr = 1'b1; wreg = rt; wval = a ^ imm_z; end
			OP_LUI:  begin wr = 1'b1; wreg = rt; wval = {ins[15:0], 16'h0000}; end
			OP_LB:  begin is_load = 1'b1; ld_signed = 1'b1; size = SZ_BYTE; end
			OP_LH:  begin is_load = 1'b1; ld_signed = 1'b1; size = SZ_HALF; end
			OP_LW:  begin is_load = 1'b1; size = SZ_WORD; end
			OP_LBU: begin is_load = 1'b1; size = SZ_BYTE; end
			OP_LHU: begin is_load = 1'b1; size = SZ_HALF; end
			OP_SB:  begin is_store = 1'b1; size = SZ_BYTE; end
			OP_SH:  begin is_store = 1'b1; size = SZ_HALF; end
			OP_SW:  begin is_store = 1'b1; size = SZ_WORD; end
			default: st = ST_ILLEGAL_INSTR;
		endcase

		// Aligned accesses never straddle the end, so the start address decides.
		case (size)
			SZ_BYTE: begin
				addr_ok   = 1'b1;
				x.byte_en = 4'b0001 << x.addr[1:0];
				ld_val    = ld_signed ? {{24{sh_data[7]}}, sh_data[7:0]}
				                      : {24'd0, sh_data[7:0]};
			end
			SZ_HALF: begin
				addr_ok   = !x.addr[0];
				x.byte_en = 4'b0011 << x.addr[1:0];
				ld_val    = ld_signed ? {{16{sh_data[15]}}, sh_data[15:0]}
				                      : {16'd0, sh_data[15:0]};
			end
			default: begin
				addr_ok   = x.addr[1:0] == 2'b00;
				x.byte_en = 4'b1111;
				ld_val    = sh_data;
			end
		endcase
		addr_ok   = addr_ok && ({1'b0, x.addr} < 33'(MEM_BYTES));
		x.st_data = b << {x.addr[1:0], 3'b000};

		if (is_load || is_store) begin
			if (!addr_ok) begin
				st = ST_MEM_FAULT;
			end else if (is_load) begin
				wr   = 1'b1;
				wreg = rt;
				wval = ld_val;
			end
		end

		fault = st == ST_ILLEGAL_INSTR || st == ST_ILLEGAL_SYSCALL ||
		        st == ST_MEM_FAULT;

		if (halted) begin
			x.npc      = pc;
			x.status   = ST_HALTED;
		end else begin
			x.status   = st;
			x.sys_out  = st == ST_SYSCALL || st == ST_EXIT || st == ST_ILLEGAL_SYSCALL;
			x.halt_set = fault || st == ST_EXIT;
			x.ld_issue = is_load && addr_ok;
			x.st_en    = is_store && addr_ok;
			if (fault) begin
				x.npc = pc;
			end else if (wr && wreg != REG_ZERO) begin
				x.wb_valid = 1'b1;
				x.wb_reg   = wreg;
				x.wb_value = wval;
			end
		end
	end

endmodule

// File: hw/rtl/mips_subset_execute_unit.sv
`timescale 1ns / 1ps
// Executes one MIPS32 integer instruction per item and returns one result per item.
// An instruction is latched with its two source registers, then executed by single-pass
// logic into the result register, so most items complete at one per cycle unless res_stall
// holds the result; a load first registers its data memory read. After reset the block runs
// a clearing pass over the data memory and register file before it takes its first item.
module mips_subset_execute_unit import mseu_pkg::*; #(
	parameter int MEM_WORDS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        instr_valid,
	output logic        instr_stall,
	input  logic [31:0] instruction,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [31:0] next_pc,
	output logic [2:0]  status,
	output logic        wb_valid,
	output logic [4:0]  wb_reg,
	output logic [31:0] wb_value,
	output logic [31:0] syscall_code,
	output logic [31:0] syscall_arg
);

	localparam int AW = $clog2(MEM_WORDS);

	logic [31:0] mem [MEM_WORDS];

	logic          s1_vld_q, ld_ph_q, clearing_q, halted_q;
	logic [AW-1:0] clr_cnt_q, idx;
	logic [31:0]   ins_s1, pc_q, rdata_q, a_s1, b_s1, r2_q, r4_q;
	logic          accept, done, out_free;
	exec_t         x;

	assign out_free    = !res_valid || !res_stall;
	assign done        = s1_vld_q && out_free && (!x.ld_issue || ld_ph_q);
	assign instr_stall = clearing_q || (s1_vld_q && !done);
	assign accept      = instr_valid && !instr_stall;
	assign idx         = x.addr[AW+1:2];

	mseu_regfile u_rf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.ra      (instruction[25:21]),
		.rb      (instruction[20:16]),
		.we      (done && x.wb_valid),
		.wa      (x.wb_reg),
		.wd      (x.wb_value),
		.clr_en  (clearing_q && clr_cnt_q < AW'(32)),
		.clr_idx (clr_cnt_q[4:0]),
		.a_q     (a_s1),
		.b_q     (b_s1),
		.r2_q    (r2_q),
		.r4_q    (r4_q)
	);

	mseu_exec #(.MEM_WORDS(MEM_WORDS)) u_exec (
		.ins    (ins_s1),
		.a      (a_s1),
		.b      (b_s1),
		.pc     (pc_q),
		.r2     (r2_q),
		.halted (halted_q),
		.rdata  (rdata_q),
		.x      (x)
	);

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_cnt_q] <= '0;
		end else if (done && x.st_en) begin
			for (int i = 0; i < 4; i++) begin
				if (x.byte_en[i]) mem[idx][8*i +: 8] <= x.st_data[8*i +: 8];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_vld_q && x.ld_issue && !ld_ph_q) begin
			rdata_q <= mem[idx];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) ins_s1 <= instruction;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
			s1_vld_q   <= 1'b0;
			ld_ph_q    <= 1'b0;
			pc_q       <= RESET_PC;
			halted_q   <= 1'b0;
			res_valid  <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
				if (clr_cnt_q == AW'(MEM_WORDS - 1)) clearing_q <= 1'b0;
			end
			if (accept) s1_vld_q <= 1'b1;
			else if (done) s1_vld_q <= 1'b0;
			if (done) ld_ph_q <= 1'b0;
			else if (s1_vld_q && x.ld_issue) ld_ph_q <= 1'b1;
			if (done) begin
				pc_q <= x.npc;
				if (x.halt_set) halted_q <= 1'b1;
				res_valid <= 1'b1;
			end else if (!res_stall) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			next_pc      <= x.npc;
			status       <= x.status;
			wb_valid     <= x.wb_valid;
			wb_reg       <= x.wb_reg;
			wb_value     <= x.wb_value;
			syscall_code <= x.sys_out ? r2_q : 32'd0;
			syscall_arg  <= x.sys_out ? r4_q : 32'd0;
		end
	end

endmodule

// File: test/mseu_checker.sv
`timescale 1ns / 1ps
module mseu_checker import mseu_pkg::*; #(
	parameter int MEM_WORDS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        instr_valid,
	input  logic        instr_stall,
	input  logic [31:0] instruction,
	input  logic        res_valid,
	input  logic        res_stall,
	input  logic [31:0] next_pc,
	input  logic [2:0]  status,
	input  logic        wb_valid,
	input  logic [4:0]  wb_reg,
	input  logic [31:0] wb_value,
	input  logic [31:0] syscall_code,
	input  logic [31:0] syscall_arg,
	output int          errors,
	output int          pending
);

	typedef struct {
		logic [31:0] npc;
		status_t     st;
		logic        wbv;
		logic [4:0]  wbr;
		logic [31:0] wbval;
		logic [31:0] code;
		logic [31:0] arg;
	} retire_t;

	logic [31:0] pc_q;
	logic [31:0] gpr [32];
	logic [31:0] dmem [MEM_WORDS];
	logic        stopped;
	retire_t     retire_q [$];
	int          err_cnt;

	task automatic execute(input logic [31:0] ins, output retire_t r);
		logic [5:0]  op;
		logic [5:0]  fn;
		logic [4:0]  rs, rt, rd, sh, wreg;
		logic [31:0] a, b, pc4, npc, se, addr, wval, word, mask;
		logic        wr, ld, ld_sgn, sto;
		status_t     st;
		int          nbytes;
		op = ins[31:26];
		rs = ins[25:21];
		rt = ins[20:16];
		rd = ins[15:11];
		sh = ins[10:6];
		fn = ins[5:0];
		se = {{16{ins[15]}}, ins[15:0]};
		a = gpr[rs];
		b = gpr[rt];
		pc4 = pc_q + 32'd4;
		npc = pc4;
		st = ST_OK;
		wr = 1'b0;
		wreg = '0;
		wval = '0;
		ld = 1'b0;
		ld_sgn = 1'b0;
		sto = 1'b0;
		nbytes = 0;
		addr = a + se;
		r = '{npc: pc_q, st: ST_HALTED, wbv: 1'b0, wbr: '0, wbval: '0, code: '0, arg: '0};
		if (stopped)
			return;
		case (op)
			OP_SPECIAL: begin
				wr = 1'b1;
				wreg = rd;
				case (fn)
					FN_SLL: wval = b << sh;
					FN_SRL: wval = b >> sh;
					FN_SRA: wval = $unsigned($signed(b) >>> sh);
					FN_JR: begin
						wr = 1'b0;
						npc = a;
					end
					FN_JALR: begin
						wval = pc4;
						npc = a;
					end
					FN_SYSCALL: begin
						wr = 1'b0;
						if (gpr[REG_SYS_CODE] == SYS_PRINT_INT ||
							gpr[REG_SYS_CODE] == SYS_PRINT_STR ||
							gpr[REG_SYS_CODE] == SYS_PRINT_CHAR)
							st = ST_SYSCALL;
						else if (gpr[REG_SYS_CODE] == SYS_EXIT)
							st = ST_EXIT;
						else
							st = ST_ILLEGAL_SYSCALL;
					end
					FN_ADDU: wval = a + b;
					FN_SUBU: wval = a - b;
					FN_AND:  wval = a & b;
					FN_OR:   wval = a | b;
					FN_XOR:  wval = a ^ b;
					FN_NOR:  wval = ~(a | b);
					FN_SLT:  wval = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
					FN_SLTU: wval = (a < b) ? 32'd1 : 32'd0;
					default: begin
						wr = 1'b0;
						st = ST_ILLEGAL_INSTR;
					end
				endcase
			end
			OP_J:   npc = {pc4[31:28], ins[25:0], 2'b00};
			OP_JAL: begin
				wr = 1'b1;
				wreg = REG_RA;
				wval = pc4;
				npc = {pc4[31:28], ins[25:0], 2'b00};
			end
			OP_BEQ: if (a == b) npc = pc4 + (se << 2);
			OP_BNE: if (a != b) npc = pc4 + (se << 2);
			OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI: begin
				wr = 1'b1;
				wreg = rt;
				case (op)
					OP_ADDIU: wval = a + se;
					OP_SLTI:  wval = ($signed(a) < $signed(se)) ? 32'd1 : 32'd0;
					OP_SLTIU: wval = (a < se) ? 32'd1 : 32'd0;
					OP_ANDI:  wval = a & {16'h0, ins[15:0]};
					OP_ORI:   wval = a | {16'h0, ins[15:0]};
					OP_XORI:  wval = a ^ {16'h0, ins[15:0]};
					default:  wval = {ins[15:0], 16'h0};
				endcase
			end
			OP_LB:  begin ld = 1'b1; ld_sgn = 1'b1; nbytes = 1; end
			OP_LH:  begin ld = 1'b1; ld_sgn = 1'b1; nbytes = 2; end
			OP_LW:  begin ld = 1'b1; nbytes = 4; end
			OP_LBU: begin ld = 1'b1; nbytes = 1; end
			OP_LHU: begin ld = 1'b1; nbytes = 2; end
			OP_SB:  begin sto = 1'b1; nbytes = 1; end
			OP_SH:  begin sto = 1'b1; nbytes = 2; end
			OP_SW:  begin sto = 1'b1; nbytes = 4; end
			default: st = ST_ILLEGAL_INSTR;
		endcase

		if (ld || sto) begin
			mask = (nbytes == 1) ? 32'hff : ((nbytes == 2) ? 32'hffff : 32'hffff_ffff);
			if ((addr & (nbytes - 1)) != 0 ||
				64'(addr) + 64'(nbytes) > 64'(MEM_WORDS) * 64'd4) begin
				st = ST_MEM_FAULT;
			end else if (ld) begin
				word = dmem[addr >> 2];
				wval = (word >> (addr[1:0] * 8)) & mask;
				if (ld_sgn)
					wval = (nbytes == 1) ? {{24{wval[7]}}, wval[7:0]}
						: {{16{wval[15]}}, wval[15:0]};
				wr = 1'b1;
				wreg = rt;
			end else begin
				mask = mask << (addr[1:0] * 8);
				dmem[addr >> 2] = (dmem[addr >> 2] & ~mask) | ((b << (addr[1:0] * 8)) & mask);
			end
		end

		r.st = st;
		if (st == ST_SYSCALL || st == ST_EXIT || st == ST_ILLEGAL_SYSCALL) begin
			r.code = gpr[REG_SYS_CODE];
			r.arg = gpr[REG_SYS_ARG];
		end
		if (st == ST_ILLEGAL_INSTR || st == ST_ILLEGAL_SYSCALL || st == ST_MEM_FAULT) begin
			stopped = 1'b1;
			return;
		end
		if (wr && wreg != REG_ZERO) begin
			gpr[wreg] = wval;
			r.wbv = 1'b1;
			r.wbr = wreg;
			r.wbval = wval;
		end
		pc_q = npc;
		r.npc = npc;
		if (st == ST_EXIT)
			stopped = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		retire_t r;
		if (!arst_n) begin
			pc_q = RESET_PC;
			for (int i = 0; i < 32; i++)
				gpr[i] = '0;
			for (int i = 0; i < MEM_WORDS; i++)
				dmem[i] = '0;
			stopped = 1'b0;
			retire_q.delete();
			err_cnt = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			// Retire before predicting, so a result never meets the item accepted at this edge.
			if (res_valid && !res_stall) begin
				if (retire_q.size() == 0) begin
					$error("result with no instruction outstanding: next_pc=%h", next_pc);
					err_cnt++;
				end else begin
					r = retire_q.pop_front();
					if (next_pc !== r.npc) begin
						$error("next_pc: expected %h, actual %h", r.npc, next_pc);
						err_cnt++;
					end
					if (status !== r.st) begin
						$error("status: expected %0d, actual %0d", r.st, status);
						err_cnt++;
					end
					if (wb_valid !== r.wbv) begin
						$error("wb_valid: expected %0d, actual %0d", r.wbv, wb_valid);
						err_cnt++;
					end
					if (wb_reg !== r.wbr) begin
						$error("wb_reg: expected %0d, actual %0d", r.wbr, wb_reg);
						err_cnt++;
					end
					if (wb_value !== r.wbval) begin
						$error("wb_value: expected %h, actual %h", r.wbval, wb_value);
						err_cnt++;
					end
					if (syscall_code !== r.code) begin
						$error("syscall_code: expected %h, actual %h", r.code, syscall_code);
						err_cnt++;
					end
					if (syscall_arg !== r.arg) begin
						$error("syscall_arg: expected %h, actual %h", r.arg, syscall_arg);
						err_cnt++;
					end
				end
			end
			if (instr_valid && !instr_stall) begin
				execute(instruction, r);
				retire_q.push_back(r);
			end
			errors <= err_cnt;
			pending <= retire_q.size();
		end
	end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import mseu_pkg::*;

	localparam int MEM_WORDS = 4096;
	localparam int RANDOM_ITEMS = 1100;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [5:0] OP_UNUSED = 6'h3f;
	localparam logic [5:0] FN_UNUSED = 6'h3f;
	// Registers that random traffic never picks as a destination: syscall code, syscall
	// argument (set by syscall sequences) and the load/store base, fixed at mid data memory.
	localparam logic [4:0] REG_V0 = 5'd2;
	localparam logic [4:0] REG_A0 = 5'd4;
	localparam logic [4:0] REG_BASE = 5'd28;
	localparam logic [15:0] BASE_ADDR = 16'h2000;

	typedef enum int {END_EXIT, END_BAD_INSTR, END_BAD_SYSCALL, END_MEM_FAULT} finish_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        instr_valid = 1'b0;
	logic        instr_stall;
	logic [31:0] instruction = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [31:0] next_pc;
	logic [2:0]  status;
	logic        wb_valid;
	logic [4:0]  wb_reg;
	logic [31:0] wb_value;
	logic [31:0] syscall_code;
	logic [31:0] syscall_arg;
	int          errors;
	int          pending;
	int          cycles = 0;
	int          sent = 0;
	int          syscalls = 0;
	bit          quiet = 1'b0;
	finish_kind_t finish_kind;

	logic [5:0] alu_fns [11] = '{FN_SLL, FN_SRL, FN_SRA, FN_ADDU, FN_SUBU, FN_AND, FN_OR,
		FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
	logic [5:0] imm_ops [7] = '{OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI,
		OP_LUI};
	logic [5:0] load_ops [5] = '{OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU};
	logic [5:0] store_ops [3] = '{OP_SB, OP_SH, OP_SW};

	always #2 clk = ~clk;

	mips_subset_execute_unit #(.MEM_WORDS(MEM_WORDS)) dut (.*);

	mseu_checker #(.MEM_WORDS(MEM_WORDS)) u_checker (.*);

	always @(posedge clk) begin
		res_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 12);
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic [31:0] rtype(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
		logic [4:0] rd, logic [4:0] sh);
		return {OP_SPECIAL, rs, rt, rd, sh, fn};
	endfunction

	function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
		logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic [4:0] free_reg();
		logic [4:0] r;
		r = 5'($urandom_range(0, 31));
		if (r == REG_V0 || r == REG_A0 || r == REG_BASE)
			r = r ^ 5'd1;
		return r;
	endfunction

	// Offset from the base register that stays inside the memory and is aligned to nbytes.
	function automatic logic [15:0] mem_offset(int nbytes);
		int off;
		if ($urandom_range(0, 1))
			off = $urandom_range(0, 127) - 64;
		else
			off = $urandom_range(0, 4 * MEM_WORDS - 1) - 2 * MEM_WORDS;
		off = off & ~(nbytes - 1);
		return off[15:0];
	endfunction

	task automatic send(input logic [31:0] ins);
		instr_valid <= 1'b1;
		instruction <= ins;
		@(posedge clk);
		while (instr_stall)
			@(posedge clk);
		sent++;
		if (!quiet && $urandom_range(0, 99) < 12) begin
			instr_valid <= 1'b0;
			instruction <= $urandom;
			repeat ($urandom_range(1, 4))
				@(posedge clk);
		end
	endtask

	task automatic send_syscall(input logic [31:0] code);
		send(itype(OP_ADDIU, 5'd0, REG_V0, code[15:0]));
		send(itype(OP_LUI, 5'd0, REG_A0, 16'($urandom)));
		send(itype(OP_ORI, REG_A0, REG_A0, 16'($urandom)));
		send(rtype(FN_SYSCALL, 5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom)));
		syscalls++;
	endtask

	task automatic send_random();
		int pick;
		int nbytes;
		logic [5:0] op;
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			send(rtype(alu_fns[$urandom_range(0, 10)], 5'($urandom), 5'($urandom),
				free_reg(), 5'($urandom)));
		end else if (pick < 50) begin
			send(itype(imm_ops[$urandom_range(0, 6)], 5'($urandom), free_reg(),
				16'($urandom)));
		end else if (pick < 65) begin
			op = load_ops[$urandom_range(0, 4)];
			nbytes = (op == OP_LW) ? 4 : ((op == OP_LH || op == OP_LHU) ? 2 : 1);
			send(itype(op, REG_BASE, free_reg(), mem_offset(nbytes)));
		end else if (pick < 80) begin
			op = store_ops[$urandom_range(0, 2)];
			nbytes = (op == OP_SW) ? 4 : ((op == OP_SH) ? 2 : 1);
			send(itype(op, REG_BASE, 5'($urandom), mem_offset(nbytes)));
		end else if (pick < 92) begin
			case ($urandom_range(0, 5))
				0: send({OP_J, 26'($urandom)});
				1: send({OP_JAL, 26'($urandom)});
				2: send(itype(OP_BEQ, 5'($urandom), 5'($urandom), 16'($urandom)));
				3: send(itype(OP_BNE, 5'($urandom), 5'($urandom), 16'($urandom)));
				4: send(rtype(FN_JR, 5'($urandom), 5'($urandom), 5'($urandom),
					5'($urandom)));
				default: send(rtype(FN_JALR, 5'($urandom), 5'($urandom), free_reg(),
					5'($urandom)));
			endcase
		end else begin
			case ($urandom_range(0, 2))
				0: send_syscall(SYS_PRINT_INT);
				1: send_syscall(SYS_PRINT_STR);
				default: send_syscall(SYS_PRINT_CHAR);
			endcase
		end
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	initial begin
		logic [31:0] code;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: operand extremes, most operations, writes to register 0, memory edges.
		send(itype(OP_ORI, 5'd0, REG_BASE, BASE_ADDR));
		send(itype(OP_LUI, 5'd0, 5'd5, 16'hffff));
		send(itype(OP_ORI, 5'd5, 5'd5, 16'hffff));
		send(itype(OP_LUI, 5'd0, 5'd6, 16'h8000));
		send(itype(OP_ADDIU, 5'd0, 5'd7, 16'h7fff));
		send(itype(OP_ADDIU, 5'd0, 5'd8, 16'h8000));
		send(rtype(FN_SRA, 5'd0, 5'd6, 5'd9, 5'd31));
		send(rtype(FN_SRL, 5'd0, 5'd6, 5'd10, 5'd31));
		send(rtype(FN_SLL, 5'd0, 5'd5, 5'd11, 5'd31));
		send(rtype(FN_ADDU, 5'd5, 5'd5, 5'd12, 5'd0));
		send(rtype(FN_SUBU, 5'd0, 5'd6, 5'd13, 5'd0));
		send(rtype(FN_NOR, 5'd6, 5'd7, 5'd14, 5'd0));
		send(rtype(FN_SLT, 5'd6, 5'd7, 5'd15, 5'd0));
		send(rtype(FN_SLTU, 5'd6, 5'd7, 5'd16, 5'd0));
		send(itype(OP_SLTI, 5'd6, 5'd17, 16'h8000));
		send(itype(OP_SLTIU, 5'd5, 5'd18, 16'hffff));
		send(itype(OP_ADDIU, 5'd5, 5'd0, 16'h0001));
		send(itype(OP_SW, REG_BASE, 5'd5, 16'h1ffc));
		send(itype(OP_SH, REG_BASE, 5'd8, 16'he000));
		send(itype(OP_SB, REG_BASE, 5'd6, 16'h1fff));
		send(itype(OP_LB, REG_BASE, 5'd19, 16'h1ffe));
		send(itype(OP_LBU, REG_BASE, 5'd19, 16'h1fff));
		send(itype(OP_LH, REG_BASE, 5'd20, 16'he000));
		send(itype(OP_LHU, REG_BASE, 5'd20, 16'he000));
		send(itype(OP_LW, REG_BASE, 5'd21, 16'h1ffc));
		send(itype(OP_BEQ, 5'd0, 5'd0, 16'hffff));
		send(itype(OP_BNE, 5'd5, 5'd0, 16'h7fff));
		send({OP_J, 26'h3ffffff});
		send({OP_JAL, 26'h0});
		send(rtype(FN_JALR, REG_BASE, 5'd0, 5'd22, 5'd0));
		send(rtype(FN_JR, 5'd6, 5'd0, 5'd0, 5'd0));
		send_syscall(SYS_PRINT_INT);
		send_syscall(SYS_PRINT_STR);
		send_syscall(SYS_PRINT_CHAR);

		// The sender holds off here until every outstanding result has retired.
		instr_valid <= 1'b0;
		wait_drained();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			quiet = (i >= 500 && i < 750);
			send_random();
		end
		quiet = 1'b0;

		// Only one terminating event fits in a run, so the seed picks which one.
		finish_kind = finish_kind_t'($urandom_range(0, 3));
		case (finish_kind)
			END_EXIT: send_syscall(SYS_EXIT);
			END_BAD_INSTR:
				if ($urandom_range(0, 1))
					send(itype(OP_UNUSED, 5'($urandom), 5'($urandom), 16'($urandom)));
				else
					send(rtype(FN_UNUSED, 5'($urandom), 5'($urandom), 5'($urandom),
						5'($urandom)));
			END_BAD_SYSCALL: begin
				code = $urandom_range(0, 65535);
				if (code == SYS_PRINT_INT || code == SYS_PRINT_STR || code == SYS_EXIT ||
					code == SYS_PRINT_CHAR)
					code = 32'd0;
				send_syscall(code);
			end
			default:
				if ($urandom_range(0, 1))
					send(itype(OP_LH, REG_BASE, 5'd1, 16'h0001));
				else
					send(itype(OP_SW, REG_BASE, 5'd1, 16'h7ffc));
		endcase
		// Once halted, the block answers every item with the held PC.
		repeat (6)
			send_random();
		instr_valid <= 1'b0;

		wait_drained();
		repeat (20)
			@(posedge clk);
		$display("Ran %0d instructions: directed operand and memory edges, random ALU, memory,",
			sent);
		$display("branch and jump traffic, %0d syscalls, then ending by %s and halted items.",
			syscalls, finish_kind.name());
		if (errors == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/mseu_pkg.sv
hw/rtl/mseu_regfile.sv
hw/rtl/mseu_exec.sv
hw/rtl/mips_subset_execute_unit.sv
test/mseu_checker.sv
test/tb_top.sv
